// ===== hdl/zrbd_pkg.sv =====
// Shared constants, types and codes for the zero-run block deframer and checker.
package zrbd_pkg;

	localparam int PAYLOAD_BYTES     = 40;
	localparam int SYNC_ZERO_RUN     = 41;
	localparam int BLOCKS_PER_FRAME  = 51;
	localparam int FRAMES_PER_PERIOD = 60;

	// The byte counter also counts the zero run, so it is at least six bits wide.
	localparam int CNT_W = ($clog2(PAYLOAD_BYTES + 1) > 6) ? $clog2(PAYLOAD_BYTES + 1) : 6;

	// Two banks of payload storage: the front fills one while the back walks the other.
	localparam int RAM_DEPTH = 2 * PAYLOAD_BYTES;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int ADDR_W = 3;
	localparam logic CFG_IDX_CAPTURE = 1'b0;

	localparam logic [7:0]       LETTER_BASE  = 8'h41;
	localparam logic [7:0]       LETTER_COUNT = 8'd26;
	localparam logic [5:0]       ERR_MAX      = 6'd63;
	localparam logic [15:0]      LOSS_MAX     = 16'hFFFF;
	localparam logic [CNT_W-1:0] CNT_PAYLOAD  = CNT_W'(PAYLOAD_BYTES);
	localparam logic [CNT_W-1:0] CNT_SYNC     = CNT_W'(SYNC_ZERO_RUN);
	localparam logic [CNT_W-1:0] IDX_LAST     = CNT_W'(PAYLOAD_BYTES - 1);
	localparam logic [5:0]       BLK_LAST     = 6'(BLOCKS_PER_FRAME);
	localparam logic [6:0]       BLK_END      = 7'(BLOCKS_PER_FRAME + 1);
	localparam logic [5:0]       FRAME_LAST   = 6'(FRAMES_PER_PERIOD);
	localparam logic [RAM_AW-1:0] BANK_OFFSET = RAM_AW'(PAYLOAD_BYTES);

	typedef enum logic [1:0] {
		KIND_SCREEN = 2'd0,
		KIND_LOST   = 2'd1,
		KIND_FRAME  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CMD_BLOCK = 2'd0,
		CMD_FRAME = 2'd1,
		CMD_LOSS  = 2'd2
	} cmd_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_RD   = 2'd1,
		BK_USE  = 2'd2,
		BK_LOSS = 2'd3
	} bk_state_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [5:0] block;
		logic       bank;
		logic [7:0] trailer;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [10:0] screen_index;
		logic [7:0]  screen_byte;
		logic        last;
		logic [5:0]  lost_at_block;
		logic [7:0]  lost_byte;
		logic [5:0]  frame_number;
		logic [5:0]  frame_errors;
		logic        period_done;
		logic        graphic_mode;
		logic [15:0] sync_losses;
	} res_t;

endpackage

// ===== hdl/zrbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module zrbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/zrbd_fifo.sv =====
// Short command queue between the byte front end and the block back end.
module zrbd_fifo import zrbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wcmd,
	input  logic pop,
	output cmd_t rcmd,
	output logic empty,
	output logic full
);

	cmd_t               slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] head_q;
	logic [FIFO_AW-1:0] tail_q;
	logic [FIFO_AW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign rcmd  = slot_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= wcmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/zrbd_front.sv =====
// Front end: zero-run hunt, payload capture into the bank RAM and trailer classification.
module zrbd_front import zrbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  logic [7:0]        rx_byte,
	output logic              push,
	output cmd_t              push_cmd,
	input  logic              fifo_full,
	input  logic              blk_done,
	output logic              ram_we,
	output logic [RAM_AW-1:0] ram_waddr,
	output logic [7:0]        ram_wdata
);

	logic             hunting_q;
	logic [CNT_W-1:0] cnt_q;
	logic [5:0]       blk_q;
	logic             bank_q;
	logic [1:0]       outst_q;

	logic             collecting;
	logic             accept;
	logic             match;
	logic             blk_push;
	logic [CNT_W-1:0] cnt_inc;
	logic [5:0]       blk_inc;

	assign collecting = !hunting_q && (cnt_q < CNT_PAYLOAD);
	// A bank may be refilled only once the back end holds at most one block that reads it.
	assign rx_ready   = hunting_q || (collecting ? (outst_q < 2'd2) : !fifo_full);
	assign accept     = rx_valid && rx_ready;
	assign match      = (rx_byte == {2'b00, blk_q});
	assign cnt_inc    = cnt_q + 1'b1;
	assign blk_inc    = blk_q + 1'b1;

	assign push     = accept && !hunting_q && !collecting;
	assign blk_push = push && match;

	always_comb begin
		push_cmd.block   = blk_q;
		push_cmd.bank    = bank_q;
		push_cmd.trailer = rx_byte;
		if (!match) begin
			push_cmd.kind = CMD_LOSS;
		end else if (blk_q >= BLK_LAST) begin
			push_cmd.kind = CMD_FRAME;
		end else begin
			push_cmd.kind = CMD_BLOCK;
		end
	end

	assign ram_we    = accept && collecting;
	assign ram_waddr = RAM_AW'(cnt_q) + (bank_q ? BANK_OFFSET : '0);
	assign ram_wdata = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			cnt_q     <= '0;
			blk_q     <= '0;
			bank_q    <= 1'b0;
			outst_q   <= '0;
		end else begin
			if (blk_push && !blk_done) begin
				outst_q <= outst_q + 1'b1;
			end else if (blk_done && !blk_push) begin
				outst_q <= outst_q - 1'b1;
			end
			if (accept) begin
				if (hunting_q) begin
					if (rx_byte == 8'd0) begin
						if (cnt_inc == CNT_SYNC) begin
							hunting_q <= 1'b0;
							blk_q     <= 6'd1;
							cnt_q     <= '0;
						end else begin
							cnt_q <= cnt_inc;
						end
					end else begin
						cnt_q <= '0;
					end
				end else if (collecting) begin
					cnt_q <= cnt_inc;
				end else begin
					cnt_q <= '0;
					if (match) begin
						blk_q  <= blk_inc;
						bank_q <= !bank_q;
						if ({1'b0, blk_inc} == BLK_END) begin
							hunting_q <= 1'b1;
						end
					end else begin
						hunting_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== hdl/zrbd_back.sv =====
// Back end: walks stored blocks for screen output or pattern check, closes frames and reports sync losses.
module zrbd_back import zrbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              capture_enable,
	input  logic              fifo_empty,
	output logic              pop,
	input  cmd_t              cmd,
	output logic [RAM_AW-1:0] ram_raddr,
	input  logic [7:0]        ram_rdata,
	output logic              blk_done,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	bk_state_t        state_q, state_d;
	cmd_t             cmd_q, cmd_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [10:0]      base_q, base_d;
	logic [7:0]       letter_q, letter_d;
	logic [5:0]       fc_q, fc_d;
	logic [5:0]       err_q, err_d;
	logic             need_q, need_d;
	logic [15:0]      loss_q, loss_d;
	res_t             res_q, res_d;
	logic             res_valid_q, res_valid_d;

	logic       free;
	logic [7:0] expected;
	logic [7:0] letter_inc;
	logic [5:0] fc_inc;

	assign free       = !res_valid_q || res_ready;
	assign expected   = LETTER_BASE + letter_q;
	assign letter_inc = letter_q + 1'b1;
	assign fc_inc     = fc_q + 1'b1;
	assign ram_raddr  = RAM_AW'(idx_q) + (cmd_q.bank ? BANK_OFFSET : '0);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		idx_d       = idx_q;
		base_d      = base_q;
		letter_d    = letter_q;
		fc_d        = fc_q;
		err_d       = err_q;
		need_d      = need_q;
		loss_d      = loss_q;
		res_d       = res_q;
		res_valid_d = res_valid_q && !res_ready;
		pop         = 1'b0;
		blk_done    = 1'b0;

		case (state_q)
			BK_IDLE: begin
				if (!fifo_empty) begin
					pop    = 1'b1;
					cmd_d  = cmd;
					idx_d  = '0;
					base_d = (11'(cmd.block) - 11'd1) * 11'(PAYLOAD_BYTES);
					state_d = (cmd.kind == CMD_LOSS) ? BK_LOSS : BK_RD;
				end
			end
			BK_RD: begin
				state_d = BK_USE;
			end
			BK_USE: begin
				if (cmd_q.kind == CMD_FRAME) begin
					if (free) begin
						res_d              = '0;
						res_d.kind         = KIND_FRAME;
						res_d.last         = 1'b1;
						res_d.frame_number = fc_q;
						res_d.frame_errors = err_q;
						res_d.graphic_mode = (ram_rdata != 8'd0);
						res_valid_d        = 1'b1;
						letter_d = (letter_inc == LETTER_COUNT) ? 8'd0 : letter_inc;
						if (err_q != 6'd0) begin
							err_d  = '0;
							need_d = 1'b1;
						end
						if (fc_inc >= FRAME_LAST) begin
							res_d.period_done = 1'b1;
							res_d.sync_losses = loss_q;
							loss_d            = '0;
							fc_d              = '0;
						end else begin
							fc_d = fc_inc;
						end
						blk_done = 1'b1;
						state_d  = BK_IDLE;
					end
				end else if (capture_enable) begin
					if (free) begin
						res_d              = '0;
						res_d.kind         = KIND_SCREEN;
						res_d.screen_index = base_q + 11'(idx_q);
						res_d.screen_byte  = ram_rdata;
						res_d.last         = (idx_q == IDX_LAST);
						res_valid_d        = 1'b1;
						if (idx_q == IDX_LAST) begin
							blk_done = 1'b1;
							state_d  = BK_IDLE;
						end else begin
							idx_d   = idx_q + 1'b1;
							state_d = BK_RD;
						end
					end
				end else begin
					// Only the first mismatch of a block counts; the rest is skipped.
					if (ram_rdata != expected) begin
						if (need_q) begin
							letter_d = ram_rdata - LETTER_BASE;
							need_d   = 1'b0;
						end else if (err_q < ERR_MAX) begin
							err_d = err_q + 1'b1;
						end
						blk_done = 1'b1;
						state_d  = BK_IDLE;
					end else if (idx_q == IDX_LAST) begin
						blk_done = 1'b1;
						state_d  = BK_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = BK_RD;
					end
				end
			end
			BK_LOSS: begin
				if (free) begin
					res_d               = '0;
					res_d.kind          = KIND_LOST;
					res_d.last          = 1'b1;
					res_d.lost_at_block = cmd_q.block;
					res_d.lost_byte     = cmd_q.trailer;
					res_valid_d         = 1'b1;
					if (loss_q != LOSS_MAX) begin
						loss_d = loss_q + 1'b1;
					end
					need_d  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			letter_q    <= '0;
			fc_q        <= '0;
			err_q       <= '0;
			need_q      <= 1'b1;
			loss_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			letter_q    <= letter_d;
			fc_q        <= fc_d;
			err_q       <= err_d;
			need_q      <= need_d;
			loss_q      <= loss_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		idx_q  <= idx_d;
		base_q <= base_d;
		res_q  <= res_d;
	end

endmodule

// ===== hdl/zero_run_block_deframer_checker_unit.sv =====
// Top level of the zero-run block deframer and letter-pattern checker.
//
//   channel   direction  handshake               beat
//   apb       in/out     psel/penable/pready     one register write or read
//   rx        in         rx_valid/rx_ready       one received byte
//   res       out        res_valid/res_ready     one result (screen, lost, frame end)
//
// The front takes one byte per cycle; a trailer waits only for room in the 4-deep queue,
// and a payload byte waits while both RAM banks still hold blocks the back has not walked.
// The back pops a command in its idle state, then takes each stored byte through a read state and a
// use state for the registered RAM read; a frame end reads one byte and a sync loss reads none.
// A full result register stalls the back, and the front once banks or queue fill.
// Reset clears all control state at once; payload storage needs no clearing.
module zero_run_block_deframer_checker_unit import zrbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [1:0]        kind,
	output logic [10:0]       screen_index,
	output logic [7:0]        screen_byte,
	output logic              last,
	output logic [5:0]        lost_at_block,
	output logic [7:0]        lost_byte,
	output logic [5:0]        frame_number,
	output logic [5:0]        frame_errors,
	output logic              period_done,
	output logic              graphic_mode,
	output logic [15:0]       sync_losses
);

	logic              capture_q;
	logic              push;
	cmd_t              push_cmd;
	logic              pop;
	cmd_t              head_cmd;
	logic              fifo_empty;
	logic              fifo_full;
	logic              blk_done;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [RAM_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	res_t              res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_IDX_CAPTURE) ? {31'd0, capture_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_CAPTURE) begin
			capture_q <= pwdata[0];
		end
	end

	zrbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.push      (push),
		.push_cmd  (push_cmd),
		.fifo_full (fifo_full),
		.blk_done  (blk_done),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	zrbd_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	zrbd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wcmd   (push_cmd),
		.pop    (pop),
		.rcmd   (head_cmd),
		.empty  (fifo_empty),
		.full   (fifo_full)
	);

	zrbd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.capture_enable (capture_q),
		.fifo_empty     (fifo_empty),
		.pop            (pop),
		.cmd            (head_cmd),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.blk_done       (blk_done),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res)
	);

	assign kind          = res.kind;
	assign screen_index  = res.screen_index;
	assign screen_byte   = res.screen_byte;
	assign last          = res.last;
	assign lost_at_block = res.lost_at_block;
	assign lost_byte     = res.lost_byte;
	assign frame_number  = res.frame_number;
	assign frame_errors  = res.frame_errors;
	assign period_done   = res.period_done;
	assign graphic_mode  = res.graphic_mode;
	assign sync_losses   = res.sync_losses;

endmodule

// ===== dv/zrbd_result_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the deframer's results from the beats it observes and compares them.
module zrbd_result_checker import zrbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	input  logic              rx_valid,
	input  logic              rx_ready,
	input  logic [7:0]        rx_byte,
	input  logic              res_valid,
	input  logic              res_ready,
	input  logic [1:0]        kind,
	input  logic [10:0]       screen_index,
	input  logic [7:0]        screen_byte,
	input  logic              last,
	input  logic [5:0]        lost_at_block,
	input  logic [7:0]        lost_byte,
	input  logic [5:0]        frame_number,
	input  logic [5:0]        frame_errors,
	input  logic              period_done,
	input  logic              graphic_mode,
	input  logic [15:0]       sync_losses,
	output int                mismatch_count,
	output int                results_pending
);

	localparam logic [ADDR_W-1:0] CAPTURE_ADDR = ADDR_W'(4 * int'(CFG_IDX_CAPTURE));

	logic             capture_mode;
	logic             hunting;
	logic [CNT_W-1:0] byte_count;
	logic [5:0]       block_number;
	logic [7:0]       block_store [PAYLOAD_BYTES];
	logic [7:0]       frame_letter;
	logic [5:0]       frame_counter;
	logic [5:0]       error_count;
	logic             need_pattern_sync;
	logic [15:0]      loss_tally;
	res_t             pending_results [$];
	int               mismatches;

	function automatic string describe(res_t r);
		return $sformatf({"kind %0d idx %0d byte %02h last %0b lost blk %0d byte %02h ",
			"frame %0d errs %0d period %0b gfx %0b losses %0d"},
			r.kind, r.screen_index, r.screen_byte, r.last, r.lost_at_block, r.lost_byte,
			r.frame_number, r.frame_errors, r.period_done, r.graphic_mode, r.sync_losses);
	endfunction

	task automatic close_frame();
		res_t r;
		r = '0;
		r.kind = KIND_FRAME;
		r.last = 1'b1;
		r.frame_number = frame_counter;
		r.frame_errors = error_count;
		r.graphic_mode = (block_store[0] != 8'd0);
		frame_letter = frame_letter + 8'd1;
		if (frame_letter == LETTER_COUNT)
			frame_letter = '0;
		if (error_count != '0) begin
			error_count = '0;
			need_pattern_sync = 1'b1;
		end
		frame_counter = frame_counter + 6'd1;
		if (frame_counter >= FRAME_LAST) begin
			r.period_done = 1'b1;
			r.sync_losses = loss_tally;
			loss_tally = '0;
			frame_counter = '0;
		end
		pending_results.push_back(r);
	endtask

	// A block with a good trailer: the last block closes the frame, the others are
	// either shown as screen bytes or checked against the current letter.
	task automatic walk_block();
		res_t       r;
		logic [7:0] want;
		logic       found;
		found = 1'b0;
		if (block_number >= BLK_LAST) begin
			close_frame();
		end else if (capture_mode) begin
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				r = '0;
				r.kind = KIND_SCREEN;
				r.screen_index = 11'((int'(block_number) - 1) * PAYLOAD_BYTES + i);
				r.screen_byte = block_store[i];
				r.last = (i == PAYLOAD_BYTES - 1);
				pending_results.push_back(r);
			end
		end else begin
			for (int i = 0; i < PAYLOAD_BYTES && !found; i++) begin
				want = LETTER_BASE + frame_letter;
				if (block_store[i] != want) begin
					found = 1'b1;
					if (need_pattern_sync) begin
						frame_letter = block_store[i] - LETTER_BASE;
						need_pattern_sync = 1'b0;
					end else if (error_count < ERR_MAX) begin
						error_count = error_count + 6'd1;
					end
				end
			end
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		res_t r;
		if (hunting) begin
			if (b == 8'd0) begin
				byte_count = byte_count + 1'b1;
				if (byte_count == CNT_SYNC) begin
					hunting = 1'b0;
					block_number = 6'd1;
					byte_count = '0;
				end
			end else begin
				byte_count = '0;
			end
		end else if (byte_count < CNT_PAYLOAD) begin
			block_store[byte_count] = b;
			byte_count = byte_count + 1'b1;
		end else if (b == 8'(block_number)) begin
			walk_block();
			block_number = block_number + 6'd1;
			byte_count = '0;
			if (7'(block_number) == BLK_END)
				hunting = 1'b1;
		end else begin
			r = '0;
			r.kind = KIND_LOST;
			r.last = 1'b1;
			r.lost_at_block = block_number;
			r.lost_byte = b;
			pending_results.push_back(r);
			if (loss_tally != LOSS_MAX)
				loss_tally = loss_tally + 16'd1;
			need_pattern_sync = 1'b1;
			hunting = 1'b1;
			byte_count = '0;
		end
	endtask

	task automatic check_result();
		res_t got;
		res_t want;
		got = {kind, screen_index, screen_byte, last, lost_at_block, lost_byte,
			frame_number, frame_errors, period_done, graphic_mode, sync_losses};
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result beat with nothing expected: %s", $realtime, describe(got));
		end else begin
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result mismatch\n  expected %s\n  actual   %s",
						$realtime, describe(want), describe(got));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_mode = 1'b0;
			hunting = 1'b1;
			byte_count = '0;
			block_number = '0;
			foreach (block_store[i])
				block_store[i] = '0;
			frame_letter = '0;
			frame_counter = '0;
			error_count = '0;
			need_pattern_sync = 1'b1;
			loss_tally = '0;
			pending_results.delete();
			mismatches = 0;
			mismatch_count <= 0;
			results_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CAPTURE_ADDR)
				capture_mode = pwdata[0];
			if (psel && penable && !pwrite && pready && paddr == CAPTURE_ADDR &&
					prdata[0] !== capture_mode) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: capture register reads %0b, expected %0b",
						$realtime, prdata[0], capture_mode);
			end
			if (rx_valid && rx_ready)
				deframe_byte(rx_byte);
			if (res_valid && res_ready)
				check_result();
			mismatch_count <= mismatches;
			results_pending <= pending_results.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte and register stimulus, and the verdict.
module tb_top;
	import zrbd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 400;
	localparam int ITEMS_WANTED   = 460;
	localparam int BLOCK_BYTES    = PAYLOAD_BYTES + 1;
	localparam logic [ADDR_W-1:0] CAPTURE_ADDR = ADDR_W'(4 * int'(CFG_IDX_CAPTURE));

	typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_HELD} sink_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              rx_valid = 1'b0;
	logic              rx_ready;
	logic [7:0]        rx_byte = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	logic [1:0]        kind;
	logic [10:0]       screen_index;
	logic [7:0]        screen_byte;
	logic              last;
	logic [5:0]        lost_at_block;
	logic [7:0]        lost_byte;
	logic [5:0]        frame_number;
	logic [5:0]        frame_errors;
	logic              period_done;
	logic              graphic_mode;
	logic [15:0]       sync_losses;

	int         mismatch_count;
	int         results_pending;
	int         idle_cycles = 0;
	int         bytes_sent = 0;
	int         burst_left = 0;
	int         blocks_sent = 0;
	int         mode_writes = 0;
	int         screen_seen = 0;
	int         losses_seen = 0;
	int         frames_seen = 0;
	int         periods_seen = 0;
	int         sink_left = 0;
	sink_mode_t sink_mode = SINK_OPEN;
	logic [7:0] corner_bytes [8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};

	zero_run_block_deframer_checker_unit DUT (.*);
	zrbd_result_checker result_check (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The result side runs through stretches of steady, coin-flip, sparse and held-off readiness.
	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_left = (sink_mode == SINK_HELD) ? $urandom_range(1, 60) : $urandom_range(20, 400);
		end
		sink_left--;
		case (sink_mode)
			SINK_OPEN:   res_ready <= 1'b1;
			SINK_COIN:   res_ready <= 1'($urandom_range(0, 1));
			SINK_SPARSE: res_ready <= ($urandom_range(0, 5) == 0);
			default:     res_ready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && rx_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (res_valid && res_ready) begin
				case (kind)
					KIND_SCREEN: screen_seen++;
					KIND_LOST:   losses_seen++;
					KIND_FRAME: begin
						frames_seen++;
						if (period_done)
							periods_seen++;
					end
					default: ;
				endcase
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat on either channel for %0d cycles", $realtime, idle_cycles);
				$display("[zero_run_block_deframer_checker_unit] ERROR");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 40) == 0)
				gap = $urandom_range(20, 120);
			if (gap > 0) begin
				rx_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
				: $urandom_range(1, 60);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] a, input logic [31:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The mode only changes once every result is out and the back end has gone quiet.
	task automatic set_capture(input logic on);
		rx_valid <= 1'b0;
		while (results_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, CAPTURE_ADDR, 32'(on));
		apb_access(1'b0, CAPTURE_ADDR, '0);
		mode_writes++;
	endtask

	// Zero runs here always stay short of a sync and end on a nonzero byte.
	task automatic send_noise(input int n);
		int run;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				run = $urandom_range(1, SYNC_ZERO_RUN - 1);
				repeat (run) send_byte(8'd0);
			end
			send_byte(8'($urandom_range(1, 255)));
		end
	endtask

	// A sync run, then good blocks, then one block whose trailer is wrong so the
	// deframer is back to hunting when the task returns.
	task automatic send_blocks(input bit random_payload, input int good_blocks,
			input int extra_zeros, input int shift, input int err_odds);
		logic [7:0] pat;
		logic [7:0] data;
		int         bad_pos;
		repeat (SYNC_ZERO_RUN + extra_zeros) send_byte(8'd0);
		pat = LETTER_BASE + 8'(shift % int'(LETTER_COUNT));
		for (int blk = 1; blk <= good_blocks + 1; blk++) begin
			bad_pos = -1;
			if (err_odds > 0 && $urandom_range(1, err_odds) == 1)
				bad_pos = $urandom_range(0, PAYLOAD_BYTES - 1);
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				if (random_payload)
					data = 8'($urandom_range(0, 255));
				else if (i == bad_pos)
					data = pat ^ 8'($urandom_range(1, 255));
				else
					data = pat;
				send_byte(data);
			end
			if (blk > good_blocks)
				send_byte(8'(blk) ^ 8'($urandom_range(1, 255)));
			else
				send_byte(8'(blk));
		end
		blocks_sent += good_blocks;
	endtask

	initial begin
		int pick;
		int room;
		int most;
		int good;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Byte extremes while hunting, then a zero run cut short by a letter.
		foreach (corner_bytes[i])
			send_byte(corner_bytes[i]);
		repeat (15) send_byte(8'd0);
		send_byte(LETTER_BASE);

		set_capture(1'b1);
		send_blocks(1'b1, 2, 0, 0, 0);
		set_capture(1'b0);

		while (ITEMS_WANTED - bytes_sent >= SYNC_ZERO_RUN + 2 * BLOCK_BYTES) begin
			if ($urandom_range(0, 3) == 0)
				send_noise($urandom_range(1, 3));
			room = ITEMS_WANTED - bytes_sent;
			most = (room - SYNC_ZERO_RUN) / BLOCK_BYTES - 1;
			if (most < 1)
				break;
			if (most > 3)
				most = 3;
			good = $urandom_range(1, most);
			pick = $urandom_range(0, 99);
			if (pick < 15)
				send_blocks(1'b0, good, $urandom_range(1, 3), 0, 0);
			else if (pick < 40)
				send_blocks(1'b0, good, 0, $urandom_range(1, 25), 4);
			else if (pick < 55)
				send_blocks(1'b1, good, 0, 0, 0);
			else
				send_blocks(1'b0, good, 0, 0, 3);
		end

		rx_valid <= 1'b0;
		while (results_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d received bytes, %0d blocks with good trailers, %0d mode writes.",
			bytes_sent, blocks_sent, mode_writes);
		$display("Results seen: %0d screen bytes, %0d sync losses, %0d frame ends, %0d period closes.",
			screen_seen, losses_seen, frames_seen, periods_seen);
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("[zero_run_block_deframer_checker_unit] OK");
		end else begin
			$display("%0d mismatches, %0d expected results never arrived",
				mismatch_count, results_pending);
			$display("[zero_run_block_deframer_checker_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/zrbd_pkg.sv
hdl/zrbd_ram.sv
hdl/zrbd_fifo.sv
hdl/zrbd_front.sv
hdl/zrbd_back.sv
hdl/zero_run_block_deframer_checker_unit.sv
dv/zrbd_result_checker.sv
dv/tb_top.sv
